FILE: hw/rtl/dasq_pkg.sv
// ----------------------------------------------------------------------------
// dasq_pkg
// Shared types, codes and helpers of the dual actuator deploy sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dasq_pkg;

  localparam int unsigned PULSE_W = 12;
  localparam int unsigned TIME_W  = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_BRACKET  = 8'h5B;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_EXT_UC   = 8'h45;
  localparam logic [7:0] CH_RET_UC   = 8'h52;
  localparam logic [7:0] CH_STOP_UC  = 8'h53;
  localparam logic [7:0] CH_EXT_LC   = 8'h65;
  localparam logic [7:0] CH_RET_LC   = 8'h72;
  localparam logic [7:0] CH_STOP_LC  = 8'h73;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_EXTEND  = 3'd1,
    CMD_RETRACT = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_TLEFT   = 3'd4,
    CMD_TRIGHT  = 3'd5,
    CMD_TSTOP   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESC    = 2'd1,
    PM_CSI    = 2'd2
  } parse_mode_e;

  typedef enum logic [1:0] {
    XS_IDLE       = 2'd0,
    XS_EXTENDING  = 2'd1,
    XS_EXTENDED   = 2'd2,
    XS_RETRACTING = 2'd3
  } ext_state_e;

  typedef enum logic [1:0] {
    TD_STOPPED = 2'd0,
    TD_LEFT    = 2'd1,
    TD_RIGHT   = 2'd2
  } tilt_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXT_STOP    = 3'd0,
    REG_EXT_FORWARD = 3'd1,
    REG_EXT_REVERSE = 3'd2,
    REG_TILT_LEFT   = 3'd3,
    REG_TILT_RIGHT  = 3'd4,
    REG_EXT_TIMEOUT = 3'd5,
    REG_RETRACT     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    ext_state_e mode;
    logic       timeout;
  } ext_status_t;

  function automatic logic [PULSE_W-1:0] ext_pulse(
    input ext_state_e         s,
    input logic [PULSE_W-1:0] stop_us,
    input logic [PULSE_W-1:0] fwd_us,
    input logic [PULSE_W-1:0] rev_us
  );
    logic [PULSE_W-1:0] p;
    case (s)
      XS_EXTENDING:  p = fwd_us;
      XS_RETRACTING: p = rev_us;
      default:       p = stop_us;
    endcase
    return p;
  endfunction

endpackage

FILE: hw/rtl/dasq_if.sv
// ----------------------------------------------------------------------------
// dasq_if
// Handshake channels of the sequencer: input items, result items, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dasq_in_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] rx_byte;
  logic       ms_tick;
  logic       armed;
  logic       limit_one;
  logic       limit_two;

  modport source (output valid, byte_valid, rx_byte, ms_tick, armed, limit_one, limit_two,
                  input ready);
  modport sink   (input valid, byte_valid, rx_byte, ms_tick, armed, limit_one, limit_two,
                  output ready);
endinterface

interface dasq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [1:0]  ext_one_mode;
  logic [1:0]  ext_two_mode;
  logic [11:0] ext_one_pulse_us;
  logic [11:0] ext_two_pulse_us;
  logic [1:0]  tilt_drive;
  logic [11:0] tilt_pulse_us;
  logic        ext_one_timeout;
  logic        ext_two_timeout;

  modport source (output valid, command, ext_one_mode, ext_two_mode, ext_one_pulse_us,
                  ext_two_pulse_us, tilt_drive, tilt_pulse_us, ext_one_timeout,
                  ext_two_timeout, input ready);
  modport sink   (input valid, command, ext_one_mode, ext_two_mode, ext_one_pulse_us,
                  ext_two_pulse_us, tilt_drive, tilt_pulse_us, ext_one_timeout,
                  ext_two_timeout, output ready);
endinterface

interface dasq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/dual_actuator_deploy_sequencer.sv
// ----------------------------------------------------------------------------
// dual_actuator_deploy_sequencer
// Console-driven sequencer for two extenders and a tilt drive.
//
//   Channel  Dir  Handshake     Contents
//   in_i     in   valid/ready   byte_valid, rx_byte, ms_tick, armed, limits
//   cfg_i    in   valid/ready   register index and write data
//   out_o    out  valid/ready   command, modes, pulses, tilt, timeout flags
//
// State updates at the accepting edge and the result is in the output register
// from that same edge. A new item is accepted every cycle while the output
// register is empty or being taken. Reset puts all machines at rest, loads the
// register defaults and empties the output. Config writes are accepted in every
// cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_actuator_deploy_sequencer #(
  parameter int unsigned ELAPSED_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dasq_in_if.sink        in_i,
  dasq_cfg_if.sink       cfg_i,
  dasq_out_if.source     out_o
);
  import dasq_pkg::*;

  logic [PULSE_W-1:0] ext_stop_q, ext_fwd_q, ext_rev_q, tilt_lft_q, tilt_rgt_q;
  logic [TIME_W-1:0]  ext_timeout_q, retract_time_q;
  tilt_e              tilt_q, tilt_d;
  logic               accept;
  cmd_e               cmd;
  ext_status_t        st_one, st_two;
  logic [PULSE_W-1:0] tilt_pulse;
  logic               out_valid_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_stop_q     <= PULSE_W'(1500);
      ext_fwd_q      <= PULSE_W'(2000);
      ext_rev_q      <= PULSE_W'(1000);
      tilt_lft_q     <= PULSE_W'(1300);
      tilt_rgt_q     <= PULSE_W'(1700);
      ext_timeout_q  <= TIME_W'(30000);
      retract_time_q <= TIME_W'(20000);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        REG_EXT_STOP:    ext_stop_q     <= cfg_i.data[PULSE_W-1:0];
        REG_EXT_FORWARD: ext_fwd_q      <= cfg_i.data[PULSE_W-1:0];
        REG_EXT_REVERSE: ext_rev_q      <= cfg_i.data[PULSE_W-1:0];
        REG_TILT_LEFT:   tilt_lft_q     <= cfg_i.data[PULSE_W-1:0];
        REG_TILT_RIGHT:  tilt_rgt_q     <= cfg_i.data[PULSE_W-1:0];
        REG_EXT_TIMEOUT: ext_timeout_q  <= cfg_i.data[TIME_W-1:0];
        REG_RETRACT:     retract_time_q <= cfg_i.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  dasq_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .byte_valid_i (in_i.byte_valid),
    .rx_byte_i    (in_i.rx_byte),
    .cmd_o        (cmd)
  );

  dasq_extender #(.ELAPSED_BITS(ELAPSED_BITS)) u_ext_one (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .tick_i    (in_i.ms_tick),
    .limit_i   (in_i.limit_one),
    .armed_i   (in_i.armed),
    .cmd_i     (cmd),
    .timeout_i (ext_timeout_q),
    .retract_i (retract_time_q),
    .status_o  (st_one)
  );

  dasq_extender #(.ELAPSED_BITS(ELAPSED_BITS)) u_ext_two (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .tick_i    (in_i.ms_tick),
    .limit_i   (in_i.limit_two),
    .armed_i   (in_i.armed),
    .cmd_i     (cmd),
    .timeout_i (ext_timeout_q),
    .retract_i (retract_time_q),
    .status_o  (st_two)
  );

  always_comb begin
    tilt_d = tilt_q;
    if (in_i.armed) begin
      case (cmd)
        CMD_TLEFT:  tilt_d = TD_LEFT;
        CMD_TRIGHT: tilt_d = TD_RIGHT;
        CMD_TSTOP:  tilt_d = TD_STOPPED;
        CMD_STOP:   tilt_d = TD_STOPPED;
        default:    tilt_d = tilt_q;
      endcase
    end
  end

  always_comb begin
    case (tilt_d)
      TD_LEFT:  tilt_pulse = tilt_lft_q;
      TD_RIGHT: tilt_pulse = tilt_rgt_q;
      default:  tilt_pulse = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q      <= TD_STOPPED;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        tilt_q <= tilt_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.command          <= cmd;
      out_o.ext_one_mode     <= st_one.mode;
      out_o.ext_two_mode     <= st_two.mode;
      out_o.ext_one_pulse_us <= ext_pulse(st_one.mode, ext_stop_q, ext_fwd_q, ext_rev_q);
      out_o.ext_two_pulse_us <= ext_pulse(st_two.mode, ext_stop_q, ext_fwd_q, ext_rev_q);
      out_o.tilt_drive       <= tilt_d;
      out_o.tilt_pulse_us    <= tilt_pulse;
      out_o.ext_one_timeout  <= st_one.timeout;
      out_o.ext_two_timeout  <= st_two.timeout;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

FILE: hw/rtl/dasq_parser.sv
// ----------------------------------------------------------------------------
// dasq_parser
// Console escape parser that turns bytes into extender and tilt commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dasq_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          byte_valid_i,
  input  logic [7:0]    rx_byte_i,
  output dasq_pkg::cmd_e cmd_o
);
  import dasq_pkg::*;

  parse_mode_e mode_q, mode_d;

  always_comb begin
    mode_d = mode_q;
    if (byte_valid_i) begin
      case (mode_q)
        PM_NORMAL: begin
          if (rx_byte_i == CH_ESC) mode_d = PM_ESC;
        end
        PM_ESC: begin
          mode_d = (rx_byte_i == CH_BRACKET) ? PM_CSI : PM_NORMAL;
        end
        default: mode_d = PM_NORMAL;
      endcase
    end
  end

  always_comb begin
    cmd_o = CMD_NONE;
    if (byte_valid_i) begin
      case (mode_q)
        PM_NORMAL: begin
          if (rx_byte_i == CH_EXT_LC || rx_byte_i == CH_EXT_UC) cmd_o = CMD_EXTEND;
          else if (rx_byte_i == CH_RET_LC || rx_byte_i == CH_RET_UC) cmd_o = CMD_RETRACT;
          else if (rx_byte_i == CH_STOP_LC || rx_byte_i == CH_STOP_UC) cmd_o = CMD_STOP;
        end
        PM_CSI: begin
          if (rx_byte_i == CH_RIGHT) cmd_o = CMD_TRIGHT;
          else if (rx_byte_i == CH_LEFT) cmd_o = CMD_TLEFT;
          else if (rx_byte_i == CH_UP || rx_byte_i == CH_DOWN) cmd_o = CMD_TSTOP;
        end
        default: cmd_o = CMD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= PM_NORMAL;
    end else if (en_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

FILE: hw/rtl/dasq_extender.sv
// ----------------------------------------------------------------------------
// dasq_extender
// One extender machine with its limit latch and saturating elapsed counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dasq_extender #(
  parameter int unsigned ELAPSED_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          tick_i,
  input  logic                          limit_i,
  input  logic                          armed_i,
  input  dasq_pkg::cmd_e                cmd_i,
  input  logic [dasq_pkg::TIME_W-1:0]   timeout_i,
  input  logic [dasq_pkg::TIME_W-1:0]   retract_i,
  output dasq_pkg::ext_status_t         status_o
);
  import dasq_pkg::*;

  localparam int unsigned CW = (ELAPSED_BITS > TIME_W) ? ELAPSED_BITS : TIME_W;

  ext_state_e              state_q, state_d;
  logic [ELAPSED_BITS-1:0] elapsed_q, elapsed_d, elapsed_tick;
  logic                    latch_q, latch_d, latch_tick;
  logic                    timed_out;
  logic                    over_timeout, over_retract;

  always_comb begin
    elapsed_tick = elapsed_q;
    if (tick_i && (elapsed_q != {ELAPSED_BITS{1'b1}})) begin
      elapsed_tick = elapsed_q + 1'b1;
    end
    latch_tick = latch_q | limit_i;
    over_timeout = CW'(elapsed_tick) >= CW'(timeout_i);
    over_retract = CW'(elapsed_tick) >= CW'(retract_i);
  end

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_tick;
    latch_d   = latch_tick;
    timed_out = 1'b0;
    if (armed_i) begin
      if (cmd_i == CMD_STOP) begin
        state_d = XS_IDLE;
      end else if (cmd_i == CMD_RETRACT) begin
        elapsed_d = '0;
        state_d   = XS_RETRACTING;
      end else begin
        case (state_q)
          XS_IDLE: begin
            if (cmd_i == CMD_EXTEND) begin
              latch_d   = 1'b0;
              elapsed_d = '0;
              state_d   = XS_EXTENDING;
            end
          end
          XS_EXTENDING: begin
            if (latch_tick) begin
              state_d = XS_EXTENDED;
            end else if (over_timeout) begin
              state_d   = XS_IDLE;
              timed_out = 1'b1;
            end
          end
          XS_RETRACTING: begin
            if (over_retract) state_d = XS_IDLE;
          end
          default: state_d = state_q;
        endcase
      end
    end
  end

  always_comb begin
    status_o.mode    = state_d;
    status_o.timeout = timed_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= XS_IDLE;
      elapsed_q <= '0;
      latch_q   <= 1'b0;
    end else if (en_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
      latch_q   <= latch_d;
    end
  end

endmodule

FILE: sim/dual_actuator_deploy_sequencer_tb.sv
// ----------------------------------------------------------------------------
// dual_actuator_deploy_sequencer_tb
// Self-checking bench for the console-driven deploy sequencer. A clocked
// driver feeds queued console items and a clocked monitor predicts every
// result item from its own model of the escape parser, both extenders and
// the tilt drive, then checks each result field by field. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_actuator_deploy_sequencer_tb;
  import dasq_pkg::*;

  localparam int unsigned ELAPSED_BITS = 20;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       ms_tick;
    logic       armed;
    logic       limit_one;
    logic       limit_two;
  } console_item_t;

  typedef struct packed {
    cmd_e               command;
    ext_state_e         ext_one_mode;
    ext_state_e         ext_two_mode;
    logic [PULSE_W-1:0] ext_one_pulse;
    logic [PULSE_W-1:0] ext_two_pulse;
    tilt_e              tilt;
    logic [PULSE_W-1:0] tilt_pulse;
    logic               ext_one_timeout;
    logic               ext_two_timeout;
  } drive_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dasq_in_if  in_if ();
  dasq_out_if out_if ();
  dasq_cfg_if cfg_if ();

  dual_actuator_deploy_sequencer #(
    .ELAPSED_BITS(ELAPSED_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and register copies.
  logic [PULSE_W-1:0] pulse_stop    = 12'd1500;
  logic [PULSE_W-1:0] pulse_forward = 12'd2000;
  logic [PULSE_W-1:0] pulse_reverse = 12'd1000;
  logic [PULSE_W-1:0] pulse_left    = 12'd1300;
  logic [PULSE_W-1:0] pulse_right   = 12'd1700;
  logic [TIME_W-1:0]  extend_limit  = 20'd30000;
  logic [TIME_W-1:0]  retract_span  = 20'd20000;

  parse_mode_e             parse_now = PM_NORMAL;
  ext_state_e              ext_mode[2] = '{XS_IDLE, XS_IDLE};
  logic [ELAPSED_BITS-1:0] ext_elapsed[2] = '{'0, '0};
  logic                    ext_latch[2] = '{1'b0, 1'b0};
  tilt_e                   tilt_now = TD_STOPPED;

  console_item_t pending_items[$];
  drive_status_t expected_status[$];

  int  n_pushed = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_timeouts = 0;
  int  n_extended = 0;
  int  errors = 0;
  int  cycles = 0;
  int  idle_left = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  bit  in_taken = 1'b0;

  function automatic logic [PULSE_W-1:0] mode_pulse(input ext_state_e m);
    case (m)
      XS_EXTENDING:  return pulse_forward;
      XS_RETRACTING: return pulse_reverse;
      default:       return pulse_stop;
    endcase
  endfunction

  function automatic drive_status_t sequence_step(input console_item_t it);
    cmd_e          c;
    logic [1:0]    aborted;
    drive_status_t r;
    c = CMD_NONE;
    aborted = 2'b00;
    for (int k = 0; k < 2; k++) begin
      if (it.ms_tick && ext_elapsed[k] != {ELAPSED_BITS{1'b1}}) ext_elapsed[k]++;
    end
    if (it.limit_one) ext_latch[0] = 1'b1;
    if (it.limit_two) ext_latch[1] = 1'b1;
    if (it.byte_valid) begin
      case (parse_now)
        PM_NORMAL: begin
          if (it.rx_byte == CH_ESC) parse_now = PM_ESC;
          else if (it.rx_byte == CH_EXT_LC || it.rx_byte == CH_EXT_UC) c = CMD_EXTEND;
          else if (it.rx_byte == CH_RET_LC || it.rx_byte == CH_RET_UC) c = CMD_RETRACT;
          else if (it.rx_byte == CH_STOP_LC || it.rx_byte == CH_STOP_UC) c = CMD_STOP;
        end
        PM_ESC: begin
          parse_now = (it.rx_byte == CH_BRACKET) ? PM_CSI : PM_NORMAL;
        end
        default: begin
          parse_now = PM_NORMAL;
          if (it.rx_byte == CH_RIGHT) c = CMD_TRIGHT;
          else if (it.rx_byte == CH_LEFT) c = CMD_TLEFT;
          else if (it.rx_byte == CH_UP || it.rx_byte == CH_DOWN) c = CMD_TSTOP;
        end
      endcase
    end
    if (it.armed) begin
      if (c == CMD_TLEFT) tilt_now = TD_LEFT;
      else if (c == CMD_TRIGHT) tilt_now = TD_RIGHT;
      else if (c == CMD_TSTOP || c == CMD_STOP) tilt_now = TD_STOPPED;
      for (int k = 0; k < 2; k++) begin
        if (c == CMD_STOP) begin
          ext_mode[k] = XS_IDLE;
        end else if (c == CMD_RETRACT) begin
          ext_elapsed[k] = '0;
          ext_mode[k] = XS_RETRACTING;
        end else begin
          case (ext_mode[k])
            XS_IDLE: begin
              if (c == CMD_EXTEND) begin
                ext_latch[k] = 1'b0;
                ext_elapsed[k] = '0;
                ext_mode[k] = XS_EXTENDING;
              end
            end
            XS_EXTENDING: begin
              if (ext_latch[k]) begin
                ext_mode[k] = XS_EXTENDED;
              end else if (ext_elapsed[k] >= extend_limit) begin
                ext_mode[k] = XS_IDLE;
                aborted[k] = 1'b1;
              end
            end
            XS_RETRACTING: begin
              if (ext_elapsed[k] >= retract_span) ext_mode[k] = XS_IDLE;
            end
            default: ;
          endcase
        end
      end
    end
    r.command         = c;
    r.ext_one_mode    = ext_mode[0];
    r.ext_two_mode    = ext_mode[1];
    r.ext_one_pulse   = mode_pulse(ext_mode[0]);
    r.ext_two_pulse   = mode_pulse(ext_mode[1]);
    r.tilt            = tilt_now;
    r.tilt_pulse      = (tilt_now == TD_LEFT) ? pulse_left :
                        (tilt_now == TD_RIGHT) ? pulse_right : '0;
    r.ext_one_timeout = aborted[0];
    r.ext_two_timeout = aborted[1];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  // Monitor: samples all handshakes at the rising edge.
  always @(posedge clk_i) begin
    drive_status_t got;
    drive_status_t want;
    console_item_t seen;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               expected_status.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_if.valid && in_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_idx_e'(cfg_if.index))
          REG_EXT_STOP:    pulse_stop    = cfg_if.data[PULSE_W-1:0];
          REG_EXT_FORWARD: pulse_forward = cfg_if.data[PULSE_W-1:0];
          REG_EXT_REVERSE: pulse_reverse = cfg_if.data[PULSE_W-1:0];
          REG_TILT_LEFT:   pulse_left    = cfg_if.data[PULSE_W-1:0];
          REG_TILT_RIGHT:  pulse_right   = cfg_if.data[PULSE_W-1:0];
          REG_EXT_TIMEOUT: extend_limit  = cfg_if.data;
          REG_RETRACT:     retract_span  = cfg_if.data;
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        got.command         = cmd_e'(out_if.command);
        got.ext_one_mode    = ext_state_e'(out_if.ext_one_mode);
        got.ext_two_mode    = ext_state_e'(out_if.ext_two_mode);
        got.ext_one_pulse   = out_if.ext_one_pulse_us;
        got.ext_two_pulse   = out_if.ext_two_pulse_us;
        got.tilt            = tilt_e'(out_if.tilt_drive);
        got.tilt_pulse      = out_if.tilt_pulse_us;
        got.ext_one_timeout = out_if.ext_one_timeout;
        got.ext_two_timeout = out_if.ext_two_timeout;
        if (expected_status.size() == 0) begin
          errors++;
          $display("%0t: result item arrived with no expectation pending", $time);
        end else begin
          want = expected_status.pop_front();
          check_field("command", int'(want.command), int'(got.command));
          check_field("ext_one_mode", int'(want.ext_one_mode), int'(got.ext_one_mode));
          check_field("ext_two_mode", int'(want.ext_two_mode), int'(got.ext_two_mode));
          check_field("ext_one_pulse_us", int'(want.ext_one_pulse), int'(got.ext_one_pulse));
          check_field("ext_two_pulse_us", int'(want.ext_two_pulse), int'(got.ext_two_pulse));
          check_field("tilt_drive", int'(want.tilt), int'(got.tilt));
          check_field("tilt_pulse_us", int'(want.tilt_pulse), int'(got.tilt_pulse));
          check_field("ext_one_timeout", int'(want.ext_one_timeout),
                      int'(got.ext_one_timeout));
          check_field("ext_two_timeout", int'(want.ext_two_timeout),
                      int'(got.ext_two_timeout));
          n_checked++;
          n_timeouts += int'(want.ext_one_timeout) + int'(want.ext_two_timeout);
          n_extended += int'(want.ext_one_mode == XS_EXTENDED) +
                        int'(want.ext_two_mode == XS_EXTENDED);
        end
      end
      if (in_taken) begin
        seen.byte_valid = in_if.byte_valid;
        seen.rx_byte    = in_if.rx_byte;
        seen.ms_tick    = in_if.ms_tick;
        seen.armed      = in_if.armed;
        seen.limit_one  = in_if.limit_one;
        seen.limit_two  = in_if.limit_two;
        expected_status.push_back(sequence_step(seen));
        n_accepted++;
      end
    end
  end

  // Driver: input items and result backpressure change at the falling edge.
  always @(negedge clk_i) begin
    console_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_taken) begin
        if (idle_left > 0) begin
          idle_left--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 10);
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_if.valid      <= 1'b1;
          in_if.byte_valid <= it.byte_valid;
          in_if.rx_byte    <= it.rx_byte;
          in_if.ms_tick    <= it.ms_tick;
          in_if.armed      <= it.armed;
          in_if.limit_one  <= it.limit_one;
          in_if.limit_two  <= it.limit_two;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_full(input logic bv, input logic [7:0] b, input logic tick,
                           input logic arm, input logic l1, input logic l2);
    console_item_t it;
    it.byte_valid = bv;
    it.rx_byte    = b;
    it.ms_tick    = tick;
    it.armed      = arm;
    it.limit_one  = l1;
    it.limit_two  = l2;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  task automatic push_item(input logic bv, input logic [7:0] b);
    push_full(bv, b, $urandom_range(0, 3) != 0, $urandom_range(0, 9) != 0,
              $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
  endtask

  task automatic push_gap();
    if ($urandom_range(0, 3) == 0) push_item(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_mix();
    logic [7:0] letters[6];
    logic [7:0] arrows[4];
    int         sel;
    letters = '{CH_EXT_LC, CH_EXT_UC, CH_RET_LC, CH_RET_UC, CH_STOP_LC, CH_STOP_UC};
    arrows  = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT};
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      push_item(1'b1, letters[$urandom_range(0, 5)]);
    end else if (sel < 65) begin
      push_item(1'b1, CH_ESC);
      push_gap();
      push_item(1'b1, CH_BRACKET);
      push_gap();
      if ($urandom_range(0, 9) != 0) push_item(1'b1, arrows[$urandom_range(0, 3)]);
      else push_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (sel < 75) begin
      push_item(1'b1, CH_ESC);
      push_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (sel < 85) begin
      push_item(1'b1, 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 15)) push_item(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_random(input int n);
    int start;
    start = n_pushed;
    while (n_pushed - start < n) push_mix();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (n_accepted != n_pushed || expected_status.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i);
    while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [19:0] stop_us, input logic [19:0] fwd_us,
                           input logic [19:0] rev_us, input logic [19:0] left_us,
                           input logic [19:0] right_us, input logic [19:0] ext_ms,
                           input logic [19:0] ret_ms);
    write_reg(REG_EXT_STOP, stop_us);
    write_reg(REG_EXT_FORWARD, fwd_us);
    write_reg(REG_EXT_REVERSE, rev_us);
    write_reg(REG_TILT_LEFT, left_us);
    write_reg(REG_TILT_RIGHT, right_us);
    write_reg(REG_EXT_TIMEOUT, ext_ms);
    write_reg(REG_RETRACT, ret_ms);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.byte_valid = 1'b0;
    in_if.rx_byte    = '0;
    in_if.ms_tick    = 1'b0;
    in_if.armed      = 1'b0;
    in_if.limit_one  = 1'b0;
    in_if.limit_two  = 1'b0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset register values.
    push_full(1'b1, CH_EXT_LC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0);
    push_full(1'b1, CH_EXT_UC, 1'b1, 1'b1, 1'b0, 1'b1);
    push_full(1'b1, CH_RET_LC, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_RET_UC, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_STOP_LC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_BRACKET, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_RIGHT, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_BRACKET, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_LEFT, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_BRACKET, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_UP, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_ESC, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_BRACKET, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_DOWN, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_EXT_LC, 1'b1, 1'b0, 1'b0, 1'b0);
    push_full(1'b0, CH_EXT_LC, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
    push_full(1'b1, CH_ESC, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_BRACKET, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, 8'h71, 1'b1, 1'b1, 1'b0, 1'b0);
    push_full(1'b1, CH_STOP_UC, 1'b1, 1'b1, 1'b0, 1'b0);
    wait_drained();

    configure(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
              20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
              20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 40)),
              20'($urandom_range(0, 40)));
    fill_random(456);
    wait_drained();

    configure('0, '0, '0, '0, '0, '0, '0);
    fill_random(456);
    wait_drained();

    configure(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    fill_random(456);
    wait_drained();

    configure(20'($urandom_range(500, 2500)), 20'($urandom_range(500, 2500)),
              20'($urandom_range(500, 2500)), 20'($urandom_range(500, 2500)),
              20'($urandom_range(500, 2500)), 20'($urandom_range(1, 25)),
              20'($urandom_range(1, 25)));
    fill_random(300);
    wait_drained();
    quiet = 1'b1;
    fill_random(156);
    wait_drained();
    repeat (10) @(negedge clk_i);

    if (expected_status.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_status.size());
    end
    $display("Checked %0d result items from %0d input items over five register settings.",
             n_checked, n_accepted);
    $display("Seen %0d extend timeouts and %0d extended-at-limit states.",
             n_timeouts, n_extended);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
